FILE: design/sfla_pkg.sv
`timescale 1ns / 1ps

package sfla_pkg;

   // Storage shape of the free list.
   localparam int LIST_DEPTH = 16;
   localparam int SIZE_WIDTH = 16;
   // Number of entries holding 2, 4, 6, ... after reset.
   localparam int RESET_FILL = 5;

   // Request codes.
   localparam logic OP_GET = 1'b0;
   localparam logic OP_PUT = 1'b1;

   // Result status codes.
   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_EMPTY     = 2'd1,
      ST_TOO_LARGE = 2'd2,
      ST_FULL      = 2'd3
   } status_type;

   // One request item.
   typedef struct packed {
      logic        op;
      logic [15:0] block_size;
   } req_type;

   // One result item.
   typedef struct packed {
      status_type  status;
      logic [15:0] granted_size;
   } rsp_type;

   // Command broadcast to every cell of the list.
   typedef struct packed {
      logic                  get_en;
      logic                  put_en;
      logic [SIZE_WIDTH-1:0] size;
   } cmd_type;

   // What a cell shows its neighbors.
   typedef struct packed {
      logic                  valid;
      logic [SIZE_WIDTH-1:0] value;
      logic                  ge;
      logic                  after;
   } link_type;

   // Summary of the list handed to the top level.
   typedef struct packed {
      logic                  empty;
      logic                  full;
      logic                  found;
      logic [SIZE_WIDTH-1:0] granted;
   } sts_type;

endpackage

FILE: design/sfla_cell.sv
`timescale 1ns / 1ps

module sfla_cell import sfla_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  rst_valid,
   input  logic [SIZE_WIDTH-1:0] rst_value,
   input  cmd_type               cmd,
   input  link_type              left,
   input  link_type              right,
   output link_type              link,
   output logic [SIZE_WIDTH-1:0] hit_value
);

   logic                  valid_ff;
   logic                  valid_in;
   logic [SIZE_WIDTH-1:0] value_ff;
   logic [SIZE_WIDTH-1:0] value_in;
   logic                  ge;
   logic                  after;
   logic                  hit;

   // Local compares against the broadcast size.
   assign ge    = valid_ff & (value_ff >= cmd.size);
   assign after = ~valid_ff | (value_ff > cmd.size);
   assign hit   = ge & ~left.ge;

   // A get closes the gap from the right; a return opens one to the left.
   always_comb begin
      valid_in = valid_ff;
      value_in = value_ff;
      if (cmd.get_en && ge) begin
         valid_in = right.valid;
         value_in = right.value;
      end else if (cmd.put_en && after) begin
         if (left.after) begin
            valid_in = left.valid;
            value_in = left.value;
         end else begin
            valid_in = 1'b1;
            value_in = cmd.size;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= rst_valid;
         value_ff <= rst_value;
      end else begin
         valid_ff <= valid_in;
         value_ff <= value_in;
      end
   end

   assign link      = '{valid: valid_ff, value: value_ff, ge: ge, after: after};
   assign hit_value = hit ? value_ff : '0;

endmodule

FILE: design/sfla_chain.sv
`timescale 1ns / 1ps

module sfla_chain import sfla_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  cmd_type cmd,
   output sts_type sts
);

   link_type              links [LIST_DEPTH];
   logic [SIZE_WIDTH-1:0] hits  [LIST_DEPTH];
   link_type              edge_link;

   // Neighbor seen past either end of the row: empty, never at or after.
   assign edge_link = '0;

   // Row of cells, each one list entry.
   for (genvar i = 0; i < LIST_DEPTH; i++) begin : g_cell
      logic                  rst_valid;
      logic [SIZE_WIDTH-1:0] rst_value;
      link_type              left_link;
      link_type              right_link;

      assign rst_valid  = (i < RESET_FILL);
      assign rst_value  = rst_valid ? SIZE_WIDTH'(2 * (i + 1)) : '0;
      assign left_link  = (i == 0) ? edge_link : links[(i == 0) ? 0 : i - 1];
      assign right_link = (i == LIST_DEPTH - 1) ? edge_link
                        : links[(i == LIST_DEPTH - 1) ? i : i + 1];

      sfla_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .rst_valid (rst_valid),
         .rst_value (rst_value),
         .cmd       (cmd),
         .left      (left_link),
         .right     (right_link),
         .link      (links[i]),
         .hit_value (hits[i])
      );
   end

   // At most one cell hits, so its value comes out of a plain OR.
   always_comb begin
      sts.empty   = ~links[0].valid;
      sts.full    = links[LIST_DEPTH-1].valid;
      sts.found   = 1'b0;
      sts.granted = '0;
      for (int i = 0; i < LIST_DEPTH; i++) begin
         sts.found   = sts.found | links[i].ge;
         sts.granted = sts.granted | hits[i];
      end
   end

`ifndef ASSERT_OFF
   for (genvar i = 0; i < LIST_DEPTH - 1; i++) begin : g_check
      // Valid entries form a prefix of the row.
      a_prefix: assert property (@(posedge clock) disable iff (reset)
         links[i+1].valid |-> links[i].valid)
         else $error("free list has a hole");
      // Valid entries stay in ascending order.
      a_sorted: assert property (@(posedge clock) disable iff (reset)
         links[i+1].valid |-> (links[i].value <= links[i+1].value))
         else $error("free list out of order");
   end
   // A fit can only be found in a list that holds something.
   a_found: assert property (@(posedge clock) disable iff (reset)
      sts.found |-> !sts.empty)
      else $error("fit found in empty list");
`endif

endmodule

FILE: design/sorted_free_list_allocator.sv
`timescale 1ns / 1ps

// Sorted free-list allocator. Keeps up to LIST_DEPTH free block sizes in
// ascending order, one per cell of a shift row; after reset the list holds
// 2, 4, 6, 8 and 10. A get removes the smallest entry at least as large as
// the request and reports it, or reports an empty list or a request too
// large. A return inserts the size after any equal entries, or reports a
// full list and drops it. Every request gives one result, registered in
// the cycle after the request is taken. One request can be taken per
// cycle: all cells compare against the request and shift in the same
// cycle. While a result waits in the output register, a new request is
// taken only in the cycle that the waiting result is taken.
module sorted_free_list_allocator import sfla_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   logic                  accept;
   logic                  is_get;
   cmd_type               cmd;
   sts_type               sts;
   rsp_type               result;
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   rsp_type               rsp_data_ff;
   rsp_type               rsp_data_in;

   assign req_ready = ~rsp_valid_ff | rsp_ready;
   assign accept    = req_valid & req_ready;
   assign is_get    = (req_data.op == OP_GET);

   // Broadcast to the cell row.
   assign cmd.size   = SIZE_WIDTH'(req_data.block_size);
   assign cmd.get_en = accept & is_get & ~sts.empty;
   assign cmd.put_en = accept & ~is_get & ~sts.full;

   sfla_chain u_chain (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd),
      .sts   (sts)
   );

   // Result of the request being taken.
   always_comb begin
      result.granted_size = '0;
      if (is_get) begin
         if (sts.empty) begin
            result.status = ST_EMPTY;
         end else if (!sts.found) begin
            result.status = ST_TOO_LARGE;
         end else begin
            result.status       = ST_OK;
            result.granted_size = 16'(sts.granted);
         end
      end else begin
         result.status = sts.full ? ST_FULL : ST_OK;
      end
   end

   // Output register.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = result;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef ASSERT_OFF
   // Every item taken shows a result in the next cycle.
   a_result: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid_ff)
      else $error("no result after item taken");
   // A list cannot be empty and full at once.
   a_shape: assert property (@(posedge clock) disable iff (reset)
      !(sts.empty && sts.full))
      else $error("list both empty and full");
   // A failed request leaves no granted size.
   a_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.status != ST_OK) |-> (rsp_data_ff.granted_size == '0))
      else $error("granted size on failed request");
`endif

endmodule
